// File: rtl/swc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync word correlator package
// Shared types, widths, register indexes and reset values of the correlator.
// ----------------------------------------------------------------------------
package swc_pkg;

   localparam int PATTERN_W = 24;
   localparam int LEN_W     = 5;
   localparam int SCORE_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int GROUP_W   = 8;
   localparam int GCNT_W    = 4;

   typedef logic [PATTERN_W-1:0]      pattern_type;
   typedef logic [LEN_W-1:0]          len_type;
   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_PATTERN    = 2'd0,
      CSR_PATTERN_LENGTH  = 2'd1,
      CSR_MATCH_THRESHOLD = 2'd2
   } csr_reg_type;

   localparam pattern_type RST_SYNC_PATTERN    = 24'd9252;
   localparam len_type     RST_PATTERN_LENGTH  = 5'd16;
   localparam score_type   RST_MATCH_THRESHOLD = 6'sd14;

   // Stage load strobes handed from the pipeline control to the score unit.
   typedef struct packed {
      logic load_groups;
      logic load_result;
   } stage_ctl_type;

endpackage

// File: rtl/sync_word_correlator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync word correlator
// Correlates the incoming bit stream against a programmable sync word.
// ----------------------------------------------------------------------------
// Usage: each req item carries one hard-decision bit. Every item gives exactly
// one rsp item with the match flag, the score (length minus twice the
// mismatches over the window ending at that bit) and the index of the first
// window bit. The history is a row of cells, one per bit, that shift on each
// accepted item and register their own mismatch.
// rsp_valid rises once the item has passed, in order, the cell mismatch
// register, which loads at the edge that accepts the item, the group counts
// and the score and output register. One item is accepted
// per cycle while the result side keeps up.
// When rsp_stall is high the result is held; the two stages in front still
// fill, so up to two more items are accepted before req_stall rises.
// Reset clears the history to zeros, the bit index to zero and loads the
// default sync word, length 16 and threshold 14. CSR writes
// are taken on any cycle but must only be made while the block is idle.
// ----------------------------------------------------------------------------
module sync_word_correlator_top #(
   parameter int MAX_PATTERN_LEN = 24,
   parameter int POSITION_WIDTH  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_rx_bit,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_match,
   output swc_pkg::score_type        rsp_score,
   output logic [POSITION_WIDTH-1:0] rsp_window_start,
   input  logic                      csr_write,
   input  swc_pkg::csr_idx_type      csr_index,
   input  swc_pkg::pattern_type      csr_wdata
);
   import swc_pkg::*;

   pattern_type   sync_pattern_ff;
   len_type       pattern_length_ff;
   score_type     match_threshold_ff;
   len_type       len_eff;

   logic [POSITION_WIDTH-1:0] bit_count_ff;
   logic [POSITION_WIDTH-1:0] bit_count_in;
   logic [POSITION_WIDTH-1:0] start1_ff;
   logic [POSITION_WIDTH-1:0] start2_ff;
   logic [POSITION_WIDTH-1:0] start3_ff;

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic ready1, ready2, ready3;
   logic accept;
   stage_ctl_type ctl;

   logic [MAX_PATTERN_LEN-1:0] hist;
   logic [MAX_PATTERN_LEN-1:0] mis;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_pattern_ff    <= RST_SYNC_PATTERN;
         pattern_length_ff  <= RST_PATTERN_LENGTH;
         match_threshold_ff <= RST_MATCH_THRESHOLD;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SYNC_PATTERN:    sync_pattern_ff    <= csr_wdata;
            CSR_PATTERN_LENGTH:  pattern_length_ff  <= LEN_W'(csr_wdata);
            CSR_MATCH_THRESHOLD: match_threshold_ff <= SCORE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // A length of zero acts as one; lengths beyond the cell row are clipped.
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(pattern_length_ff) > MAX_PATTERN_LEN) begin
         len_eff = LEN_W'(MAX_PATTERN_LEN);
      end else begin
         len_eff = pattern_length_ff;
      end
   end

   // Pipeline control: a stage moves on when the stage after it is empty or
   // moving on itself.
   always_comb begin
      ready3          = !v3_ff || !rsp_stall;
      ready2          = !v2_ff || ready3;
      ready1          = !v1_ff || ready2;
      accept          = req_valid && ready1;
      ctl.load_groups = v1_ff && ready2;
      ctl.load_result = v2_ff && ready3;
      v1_in           = accept || (v1_ff && !ready2);
      v2_in           = ctl.load_groups || (v2_ff && !ready3);
      v3_in           = ctl.load_result || (v3_ff && !ready3);
      bit_count_in    = accept ? bit_count_ff + 1'b1 : bit_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         bit_count_ff <= '0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         bit_count_ff <= bit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start1_ff <= bit_count_ff - POSITION_WIDTH'(len_eff) + 1'b1;
      end
      if (ctl.load_groups) begin
         start2_ff <= start1_ff;
      end
      if (ctl.load_result) begin
         start3_ff <= start2_ff;
      end
   end

   for (genvar k = 0; k < MAX_PATTERN_LEN; k++) begin : g_cell
      swc_cell #(
         .POS(k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .load    (accept),
         .bit_in  ((k == 0) ? req_rx_bit : hist[(k == 0) ? 0 : k-1]),
         .pattern (sync_pattern_ff),
         .len_eff (len_eff),
         .bit_out (hist[k]),
         .mis_out (mis[k])
      );
   end

   swc_score #(
      .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
   ) u_score (
      .clock     (clock),
      .ctl       (ctl),
      .mis       (mis),
      .len_eff   (len_eff),
      .threshold (match_threshold_ff),
      .match     (rsp_match),
      .score     (rsp_score)
   );

   assign req_stall        = !ready1;
   assign rsp_valid        = v3_ff;
   assign rsp_window_start = start3_ff;

   // Stall is only raised with the first stage holding an item.
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("req_stall raised with an empty first stage");

   // The bit index advances by one for every accepted item.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> (bit_count_ff == $past(bit_count_ff) + 1'b1))
      else $error("bit index did not advance on an accepted item");

   // The score differs from the length by an even amount.
   a_score_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_score[0] == len_eff[0]))
      else $error("score parity does not match the pattern length");

   // The match flag agrees with the score and the threshold.
   a_match_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match == (rsp_score >= match_threshold_ff)))
      else $error("match flag disagrees with score and threshold");

endmodule

// File: rtl/swc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync word correlator cell
// Holds one history bit, passes it to the next cell on every accepted item and
// registers a mismatch of the entering bit with its pattern bit in the window.
// ----------------------------------------------------------------------------
module swc_cell #(
   parameter int POS = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  logic            bit_in,
   input  swc_pkg::pattern_type pattern,
   input  swc_pkg::len_type     len_eff,
   output logic            bit_out,
   output logic            mis_out
);
   import swc_pkg::*;

   logic                     hist_ff;
   logic                     hist_in;
   logic                     mis_ff;
   logic                     mis_in;
   logic [2*PATTERN_W-1:0]   pat_ext;
   logic [LEN_W-1:0]         pidx;
   logic                     in_window;
   logic                     pat_bit;

   // This cell holds the bit received POS items ago, which lines up with
   // pattern position len - 1 - POS.
   always_comb begin
      pat_ext   = {{PATTERN_W{1'b0}}, pattern};
      in_window = (32'(len_eff) > POS);
      pidx      = LEN_W'(32'(len_eff) - 32'd1 - POS);
      pat_bit   = pat_ext[pidx];
      hist_in   = load ? bit_in : hist_ff;
      mis_in    = in_window & (bit_in ^ pat_bit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= 1'b0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mis_ff <= mis_in;
      end
   end

   assign bit_out = hist_ff;
   assign mis_out = mis_ff;

endmodule

// File: rtl/swc_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync word correlator score unit
// Counts mismatches in groups of eight, then sums the groups and forms the
// correlation score and the match flag.
// ----------------------------------------------------------------------------
module swc_score #(
   parameter int MAX_PATTERN_LEN = 24
) (
   input  logic                     clock,
   input  swc_pkg::stage_ctl_type   ctl,
   input  logic [MAX_PATTERN_LEN-1:0] mis,
   input  swc_pkg::len_type         len_eff,
   input  swc_pkg::score_type       threshold,
   output logic                     match,
   output swc_pkg::score_type       score
);
   import swc_pkg::*;

   localparam int NGROUPS = (MAX_PATTERN_LEN + GROUP_W - 1) / GROUP_W;
   localparam int PAD_W   = NGROUPS * GROUP_W;
   localparam int CNT_W   = $clog2(MAX_PATTERN_LEN + 1);
   localparam int SC_W    = CNT_W + 3;

   logic [PAD_W-1:0]  mis_pad;
   logic [GCNT_W-1:0] gcnt_ff [NGROUPS];
   logic [GCNT_W-1:0] gcnt_in [NGROUPS];
   logic [CNT_W-1:0]  total;
   logic signed [SC_W-1:0] sc;
   logic signed [SC_W-1:0] thr_ext;
   score_type         score_ff;
   score_type         score_in;
   logic              match_ff;
   logic              match_in;

   always_comb begin
      mis_pad = PAD_W'(mis);
      for (int g = 0; g < NGROUPS; g++) begin
         gcnt_in[g] = '0;
         for (int b = 0; b < GROUP_W; b++) begin
            gcnt_in[g] = gcnt_in[g] + GCNT_W'(mis_pad[g*GROUP_W+b]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_groups) begin
         gcnt_ff <= gcnt_in;
      end
   end

   // Each mismatch turns a +1 term into a -1 term, so score = len - 2 * total.
   always_comb begin
      total = '0;
      for (int g = 0; g < NGROUPS; g++) begin
         total = total + CNT_W'(gcnt_ff[g]);
      end
      sc       = $signed(SC_W'(len_eff)) - $signed(SC_W'({total, 1'b0}));
      thr_ext  = SC_W'(threshold);
      score_in = SCORE_W'(sc);
      match_in = (sc >= thr_ext);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_result) begin
         score_ff <= score_in;
         match_ff <= match_in;
      end
   end

   assign score = score_ff;
   assign match = match_ff;

endmodule
